// File: rtl/frtr_pkg.sv
// Package for the free-run to TRIM range builder.
// Holds the range entry and queue push types and fixed constants; no dependencies.
package frtr_pkg;

    localparam int LBA_W   = 32;
    localparam int COUNT_W = 16;
    localparam int LEN_W   = 17;   // open run length, one chunk plus one unit
    localparam int US_W    = 8;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int QLW     = 3;

    localparam logic [LEN_W-1:0]   MAX_CHUNK     = 17'd65535;
    localparam logic [COUNT_W-1:0] CHUNK_COUNT   = 16'hFFFF;
    localparam logic [8:0]         UNIT_ZERO_AS  = 9'd256;

    localparam logic CFG_START_LBA    = 1'b0;
    localparam logic CFG_UNIT_SECTORS = 1'b1;

    typedef struct packed {
        logic [LBA_W-1:0]   lba;
        logic [COUNT_W-1:0] sector_count;
        logic               block_end;
    } entry_t;

    typedef struct packed {
        logic [1:0] num;      // entries pushed this cycle, 0 to 2
        entry_t     first;
        entry_t     second;
    } push_t;

endpackage

// File: rtl/frtr_front.sv
// Front end: accepts unit status items, tracks the open run and block count,
// and builds range entries. Depends on frtr_pkg.
module frtr_front #(
    parameter int ENTRIES_PER_BLOCK = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  mode,
    input  logic                  unit_free,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_wdata,
    output frtr_pkg::push_t       push
);
    import frtr_pkg::*;

    localparam int CW = $clog2(ENTRIES_PER_BLOCK);
    localparam logic [CW-1:0] LAST_IN_BLOCK = CW'(ENTRIES_PER_BLOCK - 1);

    logic [LBA_W-1:0] start_lba_reg, start_lba_next;
    logic [US_W-1:0]  unit_sectors_reg, unit_sectors_next;
    logic [LBA_W-1:0] next_addr_reg, next_addr_next;
    logic             run_open_reg, run_open_next;
    logic [LBA_W-1:0] run_start_reg, run_start_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [CW-1:0]    blk_cnt_reg, blk_cnt_next;

    logic [8:0]       us;
    logic [LBA_W-1:0] rs;
    logic [LEN_W-1:0] len;
    logic [CW-1:0]    cnt;
    entry_t           ent;

    always_comb begin
        us             = (unit_sectors_reg == '0) ? UNIT_ZERO_AS : {1'b0, unit_sectors_reg};
        start_lba_next    = start_lba_reg;
        unit_sectors_next = unit_sectors_reg;
        next_addr_next = next_addr_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        blk_cnt_next   = blk_cnt_reg;
        push           = '0;
        rs             = run_open_reg ? run_start_reg : next_addr_reg;
        len            = (run_open_reg ? run_len_reg : '0) + LEN_W'(us);
        cnt            = blk_cnt_reg;
        ent            = '0;

        if (accept) begin
            if (mode) begin
                // end of scan: flush remainder, pad a partial block
                if (run_open_reg) begin
                    push.first = '{lba: run_start_reg, sector_count: run_len_reg[COUNT_W-1:0],
                                   block_end: (cnt == LAST_IN_BLOCK)};
                    push.num   = 2'd1;
                    cnt        = (cnt == LAST_IN_BLOCK) ? '0 : cnt + 1'b1;
                end
                if (cnt != '0) begin
                    ent = '{lba: '0, sector_count: '0, block_end: 1'b1};
                    if (push.num == 2'd0) begin
                        push.first = ent;
                    end else begin
                        push.second = ent;
                    end
                    push.num = push.num + 2'd1;
                end
                blk_cnt_next   = '0;
                run_open_next  = 1'b0;
                run_start_next = '0;
                run_len_next   = '0;
                next_addr_next = start_lba_reg;
            end else if (unit_free) begin
                // extend or open the run; cut a full chunk once it grows past the limit
                if (len > MAX_CHUNK) begin
                    push.first = '{lba: rs, sector_count: CHUNK_COUNT,
                                   block_end: (cnt == LAST_IN_BLOCK)};
                    push.num   = 2'd1;
                    blk_cnt_next   = (cnt == LAST_IN_BLOCK) ? '0 : cnt + 1'b1;
                    run_start_next = rs + LBA_W'(MAX_CHUNK);
                    run_len_next   = len - MAX_CHUNK;
                end else begin
                    run_start_next = rs;
                    run_len_next   = len;
                end
                run_open_next  = 1'b1;
                next_addr_next = next_addr_reg + LBA_W'(us);
            end else begin
                // used unit closes any open run
                if (run_open_reg) begin
                    push.first = '{lba: run_start_reg, sector_count: run_len_reg[COUNT_W-1:0],
                                   block_end: (cnt == LAST_IN_BLOCK)};
                    push.num   = 2'd1;
                    blk_cnt_next = (cnt == LAST_IN_BLOCK) ? '0 : cnt + 1'b1;
                end
                run_open_next  = 1'b0;
                run_len_next   = '0;
                next_addr_next = next_addr_reg + LBA_W'(us);
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_START_LBA: begin
                    start_lba_next = cfg_wdata;
                    next_addr_next = cfg_wdata;
                    run_open_next  = 1'b0;
                    run_start_next = '0;
                    run_len_next   = '0;
                end
                CFG_UNIT_SECTORS: begin
                    unit_sectors_next = cfg_wdata[US_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_lba_reg    <= '0;
            unit_sectors_reg <= 8'd1;
            next_addr_reg    <= '0;
            run_open_reg     <= 1'b0;
            run_start_reg    <= '0;
            run_len_reg      <= '0;
            blk_cnt_reg      <= '0;
        end else begin
            start_lba_reg    <= start_lba_next;
            unit_sectors_reg <= unit_sectors_next;
            next_addr_reg    <= next_addr_next;
            run_open_reg     <= run_open_next;
            run_start_reg    <= run_start_next;
            run_len_reg      <= run_len_next;
            blk_cnt_reg      <= blk_cnt_next;
        end
    end

endmodule

// File: rtl/frtr_queue.sv
// Entry queue between front and back: takes up to two entries a cycle,
// gives one. Depends on frtr_pkg.
module frtr_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  frtr_pkg::push_t              push,
    input  logic                         pop,
    output frtr_pkg::entry_t             head,
    output logic                         head_valid,
    output logic [frtr_pkg::QLW-1:0]     level
);
    import frtr_pkg::*;

    entry_t             mem [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QLW-1:0]     level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QAW'(push.num);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        level_next  = level_reg + QLW'(push.num) - QLW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule

// File: rtl/frtr_back.sv
// Back end: moves queued entries into the output register and drives
// the result stream. Depends on frtr_pkg.
module frtr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  frtr_pkg::entry_t  head,
    input  logic              head_valid,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tlast
);
    import frtr_pkg::*;

    logic   valid_reg, valid_next;
    entry_t out_reg;

    always_comb begin
        // load when the register is empty or its transaction completes
        pop        = head_valid && (!valid_reg || m_tready);
        valid_next = pop || (valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.sector_count, out_reg.lba};
    assign m_tlast  = out_reg.block_end;

endmodule

// File: rtl/free_run_to_trim_ranges_top.sv
// Top level of the free-run to TRIM range builder.
// Instantiates frtr_front, frtr_queue and frtr_back; depends on frtr_pkg.
//
// Usage:
//   Input stream (s_*): one transaction per allocation unit in address order.
//   s_tuser is the mode (0 = unit status, 1 = end of scan), s_tdata[0] is
//   the free flag. Result stream (m_*): one TRIM range entry per transaction,
//   m_tdata = {sector_count, lba}, m_tlast marks the entry that ends a block
//   of ENTRIES_PER_BLOCK entries or the padding entry that closes the scan.
//   Config port: cfg_we writes cfg_wdata into register cfg_index
//   (0 = start_lba, 1 = unit_sectors) at the clock edge; write only when idle.
//   Writing start_lba also restarts the scan and drops any open run.
//
// Timing: while s_tready is high the front end takes one item every cycle;
// each item is classified and the run state updated in that same cycle, so
// the run update loop (one add and compare) sets the one-item-per-cycle rate.
// Entries pass through a four-deep queue; each is written into the queue and
// then loaded into the output register that drives m_*. An end-of-scan item
// may push two entries; the output drains one per cycle while m_tready is high.
// Reset: aresetn low (synchronous) clears the run, block count and queue and
// restores start_lba = 0, unit_sectors = 1; s_tready stays low while it is held.
// Stall: while m_tready is low the output holds; the queue fills and s_tready
// drops once fewer than two free slots remain.
module free_run_to_trim_ranges_top #(
    parameter int ENTRIES_PER_BLOCK = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [0] unit_free, [7:1] zero
    input  logic        s_tuser,     // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [31:0] lba, [47:32] sector_count
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import frtr_pkg::*;

    logic           accept;
    push_t          push;
    entry_t         head;
    logic           head_valid;
    logic           pop;
    logic [QLW-1:0] level;

    // accept only out of reset and while the queue can take a two-entry burst
    assign s_tready = aresetn && (level <= QLW'(QDEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    frtr_front #(
        .ENTRIES_PER_BLOCK(ENTRIES_PER_BLOCK)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .mode      (s_tuser),
        .unit_free (s_tdata[0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    frtr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    frtr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= QLW'(QDEPTH))
        else $error("entry queue overflow");

    // a zero sector count is only the padding entry, which ends the block
    a_zero_is_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[47:32] == 16'd0)) |-> (m_tlast && (m_tdata[31:0] == 32'd0)))
        else $error("zero-count entry is not a padding entry");

    // nothing is pushed without an accepted item
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> accept)
        else $error("entry pushed without an accepted item");

endmodule

// File: tb/free_run_to_trim_ranges_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for free_run_to_trim_ranges_top: directed table, then random scans and directed cases.
// Depends on frtr_pkg (entry_t, register indexes) and the RTL top; needs no other file.
module free_run_to_trim_ranges_top_tb;
    import frtr_pkg::*;

    localparam int ENTRIES       = 64;
    localparam logic MODE_UNIT     = 1'b0;
    localparam logic MODE_SCAN_END = 1'b1;
    localparam logic [31:0] CHUNK  = 32'd65535;
    localparam int STALL_LIMIT   = 2000;  // idle cycles before the run is declared hung
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 6;     // in-flight item with no entry, before a register write
    localparam int TAIL_CYCLES   = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [0] unit_free, [7:1] zero
    logic        s_tuser   = 1'b0;    // [0] mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;             // [31:0] lba, [47:32] sector_count
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = 32'h0;

    free_run_to_trim_ranges_top #(.ENTRIES_PER_BLOCK(ENTRIES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Range builder prediction: own copy of registers and scan state
    // ------------------------------------------------------------------
    logic [31:0] scan_origin  = 32'h0;   // start_lba register
    logic [7:0]  unit_size    = 8'd1;    // unit_sectors register
    logic [31:0] next_addr    = 32'h0;
    logic        run_open     = 1'b0;
    logic [31:0] run_start    = 32'h0;
    int          block_fill   = 0;
    entry_t      predicted [2];
    entry_t      expected_entries [$];

    int errors = 0, items_sent = 0, entries_checked = 0, block_ends = 0;
    int chunks_predicted = 0, pads_predicted = 0, reg_writes = 0;

    // Count one entry into the current block and mark it when it fills the block or is the padding entry.
    function automatic entry_t make_range(input logic [31:0] lba, input logic [15:0] cnt,
                                          input bit pad);
        entry_t e;
        e.lba          = lba;
        e.sector_count = cnt;
        e.block_end    = 1'b0;
        if (pad) begin
            e.block_end = 1'b1;
            block_fill  = 0;
            pads_predicted++;
        end else begin
            block_fill++;
            if (block_fill == ENTRIES) begin
                e.block_end = 1'b1;
                block_fill  = 0;
            end
        end
        return e;
    endfunction

    // Advance the scan by one transaction; fill predicted[] and return the entry count.
    function automatic int trim_step(input logic mode, input logic free_f);
        logic [31:0] step;
        logic [31:0] len;
        int n;
        n    = 0;
        step = (unit_size == 8'd0) ? 32'd256 : {24'd0, unit_size};
        if (mode == MODE_SCAN_END) begin
            if (run_open) begin
                len          = next_addr - run_start;
                predicted[n] = make_range(run_start, len[15:0], 1'b0);
                n++;
            end
            if (block_fill != 0) begin
                predicted[n] = make_range(32'h0, 16'h0, 1'b1);
                n++;
            end
            run_open   = 1'b0;
            run_start  = 32'h0;
            block_fill = 0;
            next_addr  = scan_origin;
        end else if (free_f) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_start = next_addr;
            end
            next_addr = next_addr + step;
            len       = next_addr - run_start;
            // emit a full chunk as soon as the open run passes the limit
            if (len > CHUNK) begin
                predicted[n] = make_range(run_start, CHUNK[15:0], 1'b0);
                n++;
                chunks_predicted++;
                run_start = run_start + CHUNK;
            end
        end else begin
            if (run_open) begin
                len          = next_addr - run_start;
                predicted[n] = make_range(run_start, len[15:0], 1'b0);
                n++;
                run_open = 1'b0;
            end
            next_addr = next_addr + step;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    entry_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            entries_checked++;
            if (m_tlast)
                block_ends++;
            if (expected_entries.size() == 0) begin
                report_mismatch($sformatf("entry lba %h count %0d with none pending",
                                          m_tdata[31:0], m_tdata[47:32]));
            end else begin
                want = expected_entries.pop_front();
                if (m_tdata[31:0] !== want.lba)
                    report_mismatch($sformatf("lba %h, expected %h", m_tdata[31:0], want.lba));
                if (m_tdata[47:32] !== want.sector_count)
                    report_mismatch($sformatf("sector_count %0d, expected %0d",
                                              m_tdata[47:32], want.sector_count));
                if (m_tlast !== want.block_end)
                    report_mismatch($sformatf("block_end %b, expected %b",
                                              m_tlast, want.block_end));
            end
        end
    end

    // Watchdog: count cycles in which no transaction and no register write happens.
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("[%0t] hung: no transaction for %0d cycles, %0d entries still pending",
                 $realtime, STALL_LIMIT, expected_entries.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    bit hold_request = 1'b0;
    bit hold_active  = 1'b0;

    initial begin : receiver
        int   r;
        int   span;
        logic rdy;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active  = 1'b0;
                hold_request = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    rdy = 1'b1; span = $urandom_range(1, 4);
                end else if (r < 55) begin
                    rdy = 1'b1; span = $urandom_range(20, 60);   // stretch with no stall
                end else if (r < 90) begin
                    rdy = 1'b0; span = $urandom_range(1, 3);
                end else if (r < 98) begin
                    rdy = 1'b0; span = $urandom_range(4, 12);
                end else begin
                    rdy = 1'b0; span = $urandom_range(30, 80);
                end
                m_tready <= rdy;
                repeat (span) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    bit offering   = 1'b0;
    int burst_left = 0;

    // Hold valid until the transaction is taken; valid stays up for a back-to-back item.
    task automatic drive_item(input logic mode, input logic free_f);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, free_f};
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic lower_valid();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    task automatic sender_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else if (r < 4) begin
            burst_left = $urandom_range(30, 60);
        end else if (r < 55) begin
            g = 0;
        end else if (r < 85) begin
            g = $urandom_range(1, 3);
        end else if (r < 97) begin
            g = $urandom_range(4, 12);
        end else begin
            g = $urandom_range(20, 50);
        end
        if (g > 0) begin
            lower_valid();
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_item(input logic mode, input logic free_f);
        int n;
        int k;
        drive_item(mode, free_f);
        n = trim_step(mode, free_f);
        for (k = 0; k < n; k++)
            expected_entries.push_back(predicted[k]);
        sender_gap();
    endtask

    // Write a register only once the block is idle: drain, then let an in-flight item settle.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        lower_valid();
        while (expected_entries.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (idx == CFG_START_LBA) begin
            scan_origin = val;
            next_addr   = val;
            run_open    = 1'b0;
            run_start   = 32'h0;
        end else begin
            unit_size = val[7:0];
        end
    endtask

    function automatic logic [7:0] pick_unit();
        case ($urandom_range(0, 9))
            0:       return 8'd0;     // taken as 256 sectors
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'hFFFF_FFFF - 32'($urandom_range(0, 4000));  // wraps soon
            default: return $urandom();
        endcase
    endfunction

    // Random scans: alternating free and used runs, mostly short, with some flipped units.
    int   scan_left = 20;
    int   run_left  = 0;
    logic run_free  = 1'b0;

    task automatic scan_traffic(input int count);
        int   k;
        int   r;
        logic f;
        for (k = 0; k < count; k++) begin
            if (scan_left == 0) begin
                scan_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 160)
                                                         : $urandom_range(8, 60);
                send_item(MODE_SCAN_END, 1'($urandom_range(0, 1)));
            end else begin
                if (run_left == 0) begin
                    if ($urandom_range(0, 9) != 0)
                        run_free = !run_free;
                    r = $urandom_range(0, 99);
                    if (r < 70)      run_left = $urandom_range(1, 4);
                    else if (r < 95) run_left = $urandom_range(5, 20);
                    else             run_left = $urandom_range(40, 80);
                end
                f = run_free;
                if ($urandom_range(0, 19) == 0)
                    f = !f;
                run_left--;
                scan_left--;
                send_item(MODE_UNIT, f);
            end
        end
    endtask

    task automatic random_phase(input int count);
        logic [31:0] w;
        if ($urandom_range(0, 2) != 0) begin
            w      = $urandom();     // upper bits are don't-care for unit_sectors
            w[7:0] = pick_unit();
            write_reg(CFG_UNIT_SECTORS, w);
        end
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_START_LBA, pick_start());
        scan_traffic(count);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_reg;
        logic        reg_idx;
        logic [31:0] reg_val;
        logic        mode;
        logic        free_f;
        bit          known;     // expected entries typed in below
        int          n_known;
        entry_t      k0;
        entry_t      k1;
    } vector_t;

    vector_t vectors [$];

    task automatic add_reg(input logic idx, input logic [31:0] val);
        vector_t v;
        v = '{default: '0};
        v.is_reg  = 1'b1;
        v.reg_idx = idx;
        v.reg_val = val;
        vectors.push_back(v);
    endtask

    task automatic add_item(input logic mode, input logic free_f);
        vector_t v;
        v = '{default: '0};
        v.mode   = mode;
        v.free_f = free_f;
        vectors.push_back(v);
    endtask

    task automatic add_known(input logic mode, input logic free_f, input int n,
                             input entry_t k0, input entry_t k1);
        vector_t v;
        v = '{default: '0};
        v.mode    = mode;
        v.free_f  = free_f;
        v.known   = 1'b1;
        v.n_known = n;
        v.k0      = k0;
        v.k1      = k1;
        vectors.push_back(v);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        vector_t     v;
        entry_t      none;
        entry_t      pad;
        logic [31:0] w;
        int          i;
        int          k;
        int          n;
        int          run_len;

        none = '0;
        pad  = entry_t'{32'h0, 16'h0, 1'b1};

        // After reset: start_lba 0, one sector per unit.
        add_known(MODE_UNIT, 1'b0, 0, none, none);        // used unit, no run open
        add_known(MODE_SCAN_END, 1'b0, 0, none, none);    // end of scan, nothing pending
        add_known(MODE_UNIT, 1'b1, 0, none, none);
        add_known(MODE_UNIT, 1'b1, 0, none, none);
        add_known(MODE_UNIT, 1'b0, 1, entry_t'{32'h0, 16'd2, 1'b0}, none);
        add_known(MODE_SCAN_END, 1'b0, 1, pad, none);     // partial block closed by padding
        add_known(MODE_UNIT, 1'b1, 0, none, none);
        add_known(MODE_SCAN_END, 1'b0, 2, entry_t'{32'h0, 16'd1, 1'b0}, pad);
        // Unit size zero means 256 sectors; the run crosses the top of the address space.
        add_reg(CFG_UNIT_SECTORS, 32'h0);
        add_reg(CFG_START_LBA, 32'hFFFF_FF00);
        add_item(MODE_UNIT, 1'b1);
        add_item(MODE_UNIT, 1'b1);
        add_known(MODE_UNIT, 1'b0, 1, entry_t'{32'hFFFF_FF00, 16'd512, 1'b0}, none);
        add_known(MODE_SCAN_END, 1'b1, 1, pad, none);     // free flag ignored at end of scan
        // Largest unit and start address.
        add_reg(CFG_UNIT_SECTORS, 32'hFFFF_FFFF);
        add_reg(CFG_START_LBA, 32'hFFFF_FFFF);
        add_item(MODE_UNIT, 1'b1);
        add_item(MODE_UNIT, 1'b0);
        add_item(MODE_UNIT, 1'b1);
        add_item(MODE_UNIT, 1'b1);
        // Restart in the middle of an open run: the run is dropped, the block count kept.
        add_reg(CFG_START_LBA, 32'h0000_1000);
        add_item(MODE_UNIT, 1'b0);
        add_item(MODE_UNIT, 1'b1);
        add_item(MODE_SCAN_END, 1'b1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < vectors.size(); i++) begin
            v = vectors[i];
            if (v.is_reg) begin
                write_reg(v.reg_idx, v.reg_val);
            end else begin
                drive_item(v.mode, v.free_f);
                n = trim_step(v.mode, v.free_f);
                if (v.known) begin
                    if (v.n_known > 0) expected_entries.push_back(v.k0);
                    if (v.n_known > 1) expected_entries.push_back(v.k1);
                end else begin
                    for (k = 0; k < n; k++)
                        expected_entries.push_back(predicted[k]);
                end
                sender_gap();
            end
        end

        random_phase(50);

        // Long free run with the largest units: passes 65535 sectors, so a full
        // chunk goes out while the run is still open, then the remainder.
        send_item(MODE_SCAN_END, 1'b0);
        write_reg(CFG_UNIT_SECTORS, $urandom_range(0, 1) ? 32'd255 : 32'd0);
        write_reg(CFG_START_LBA, pick_start());
        repeat ($urandom_range(0, 3)) send_item(MODE_UNIT, 1'b0);
        run_len = $urandom_range(258, 262);
        repeat (run_len) send_item(MODE_UNIT, 1'b1);
        send_item(MODE_UNIT, 1'b0);
        repeat ($urandom_range(1, 3)) send_item(MODE_UNIT, 1'b1);
        send_item(MODE_SCAN_END, 1'b0);

        random_phase(50);

        // Hold the receiver off while items keep coming, so the queue fills and
        // the input stalls; every pair closes a run.
        lower_valid();
        hold_request = 1'b1;
        wait (hold_active);
        for (k = 0; k < 24; k++) begin
            drive_item(MODE_UNIT, k[0] ? 1'b0 : 1'b1);
            n = trim_step(MODE_UNIT, k[0] ? 1'b0 : 1'b1);
            for (i = 0; i < n; i++)
                expected_entries.push_back(predicted[i]);
        end

        // Fill a block to one short, then end the scan on an open run: the
        // remainder completes the block and no padding follows.
        send_item(MODE_SCAN_END, 1'b0);
        w      = $urandom();
        w[7:0] = 8'($urandom_range(1, 4));
        write_reg(CFG_UNIT_SECTORS, w);
        write_reg(CFG_START_LBA, pick_start());
        for (k = 0; k < ENTRIES - 1; k++) begin
            send_item(MODE_UNIT, 1'b1);
            send_item(MODE_UNIT, 1'b0);
        end
        send_item(MODE_UNIT, 1'b1);
        send_item(MODE_SCAN_END, 1'b0);

        for (k = 0; k < 3; k++)
            random_phase(50);
        send_item(MODE_SCAN_END, 1'b0);

        // Drain, then give the block time to show any stray entry.
        lower_valid();
        while (expected_entries.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d scan transactions across %0d register writes; checked %0d entries.",
                 items_sent, reg_writes, entries_checked);
        $display("Entries included %0d full chunks, %0d padding entries, %0d block ends.",
                 chunks_predicted, pads_predicted, block_ends);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
